/* rtl/pws_pkg.sv */
// Package for the priority window scheduler.
// Holds the sequencer state type and the fixed field widths.
// No dependencies.
package pws_pkg;

  localparam int OUT_INDEX_W = 16;
  localparam int WSIZE_W = 4;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 4'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

/* rtl/priority_window_scheduler_top.sv */
// Priority window scheduler: collects packets into windows and emits their
// arrival indices, high priority first, at most one per cycle from one scanner.
// Depends on pws_pkg.
//
//  channel   | dir | tdata                    | tlast
//  ----------+-----+--------------------------+-------------
//  s_axis    | in  | [0] priority_high        | sequence_end
//  m_axis    | out | [15:0] packet_index      | run_last
//  cfg       | in  | cfg_wdata: window_size   | -
//
// A packet that closes a window of n entries is followed by a scan of two passes
// over those entries, one entry per cycle through the single index adder while
// the output is not stalled. s_axis_tready is low during the scan. The output
// register lets the next packet be taken while the final index still waits.
// Reset is synchronous.
module priority_window_scheduler_top #(
  parameter int MAX_WINDOW  = 8,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [0] priority_high
  input  logic                              s_axis_tlast,   // sequence_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pws_pkg::OUT_INDEX_W-1:0]   m_axis_tdata,   // [15:0] packet_index
  output logic                              m_axis_tlast,   // run_last
  input  logic                              cfg_we,
  input  logic [pws_pkg::WSIZE_W-1:0]       cfg_wdata
);
  import pws_pkg::*;

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_WINDOW);
  localparam logic [FILL_W-1:0] TOP_SLOT = FILL_W'(MAX_WINDOW - 1);

  state_t state, state_next;

  logic [WSIZE_W-1:0]     window_size;
  logic [INDEX_WIDTH-1:0] arrival_count;
  logic [INDEX_WIDTH-1:0] window_base;
  logic [FILL_W-1:0]      window_fill;
  logic [MAX_WINDOW-1:0]  prio;

  logic              pass;
  logic [FILL_W-1:0] scan_i;
  logic [FILL_W-1:0] emit_k;
  logic [FILL_W-1:0] scan_n;

  logic                   m_valid;
  logic [OUT_INDEX_W-1:0] m_index;
  logic                   m_last;

  // input side
  logic              in_xfer;
  logic [FILL_W-1:0] slot;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] eff_size;
  logic              flush;

  // scan side
  logic                         match;
  logic                         out_free;
  logic                         step;
  logic                         emit;
  logic                         scan_end;
  logic [FILL_W-1:0]            emit_k_inc;
  logic [INDEX_WIDTH-1:0]       index_sum;
  logic [INDEX_WIDTH+OUT_INDEX_W-1:0] index_ext;

  // window size clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_size == '0) begin
      eff_size = FILL_W'(1);
    end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
      eff_size = MAX_FILL;
    end else begin
      eff_size = FILL_W'(window_size);
    end
  end

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign slot     = (window_fill >= MAX_FILL) ? TOP_SLOT : window_fill;
  assign fill_inc = slot + FILL_W'(1);
  assign flush    = (fill_inc >= eff_size) || s_axis_tlast;

  assign match      = (prio[scan_i[SLOT_W-1:0]] == ~pass);
  assign out_free   = !m_valid || m_axis_tready;
  assign step       = (state == ST_SCAN) && (!match || out_free);
  assign emit       = step && match;
  assign scan_end   = (scan_i == scan_n - FILL_W'(1));
  assign emit_k_inc = emit_k + FILL_W'(1);
  assign index_sum  = window_base + INDEX_WIDTH'(scan_i);
  assign index_ext  = {{OUT_INDEX_W{1'b0}}, index_sum};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && flush) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && scan_end && pass) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = m_valid;
    m_axis_tdata  = m_index;
    m_axis_tlast  = m_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_size   <= WSIZE_RESET;
      arrival_count <= '0;
      window_base   <= '0;
      window_fill   <= '0;
      pass          <= 1'b0;
      scan_i        <= '0;
      emit_k        <= '0;
      scan_n        <= '0;
      m_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end

      if (in_xfer) begin
        if (slot == '0) begin
          window_base <= arrival_count;
        end
        if (flush) begin
          window_fill   <= '0;
          arrival_count <= s_axis_tlast ? '0 : arrival_count + INDEX_WIDTH'(1);
          scan_n        <= fill_inc;
          scan_i        <= '0;
          emit_k        <= '0;
          pass          <= 1'b0;
        end else begin
          window_fill   <= fill_inc;
          arrival_count <= arrival_count + INDEX_WIDTH'(1);
        end
      end

      if (step) begin
        if (scan_end) begin
          scan_i <= '0;
          pass   <= 1'b1;
        end else begin
          scan_i <= scan_i + FILL_W'(1);
        end
        if (emit) begin
          emit_k <= emit_k_inc;
        end
      end

      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prio[slot[SLOT_W-1:0]] <= s_axis_tdata[0];
    end
    if (emit) begin
      m_index <= index_ext[OUT_INDEX_W-1:0];
      m_last  <= (emit_k_inc == scan_n);
    end
  end

endmodule

/* dv/tb_priority_window_scheduler_top.sv */
// Self-checking testbench for priority_window_scheduler_top: directed windows and
// randomised sequences, with random gaps on the input and back-pressure on the output.
// Depends on pws_pkg and the scheduler RTL.
module tb_priority_window_scheduler_top;
  import pws_pkg::*;

  localparam int MAX_WINDOW = 8;
  localparam int SETTLE_CYCLES = 2 * MAX_WINDOW + 4;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] index;
    logic                   run_last;
  } sched_t;

  // Mirrors the window collector and the high-then-low ordering of each flush.
  class window_scoreboard;
    logic [WSIZE_W-1:0]     size_reg;
    logic [OUT_INDEX_W-1:0] next_index;
    logic [OUT_INDEX_W-1:0] base;
    int unsigned            fill;
    logic                   prio[MAX_WINDOW];
    sched_t                 due_q[$];
    int unsigned            errors;
    int unsigned            checked;
    int unsigned            packets;

    function new();
      size_reg = WSIZE_RESET;
      next_index = '0;
      base = '0;
      fill = 0;
      errors = 0;
      checked = 0;
      packets = 0;
    endfunction

    function void set_window_size(logic [WSIZE_W-1:0] v);
      size_reg = v;
    endfunction

    function int unsigned span();
      int unsigned s;
      s = 32'(size_reg);
      if (s == 0) s = 1;
      if (s > MAX_WINDOW) s = MAX_WINDOW;
      return s;
    endfunction

    function void note_packet(logic hi, logic fin);
      int unsigned slot;
      int unsigned n;
      int unsigned k;
      sched_t e;
      slot = fill;
      if (slot >= MAX_WINDOW) slot = MAX_WINDOW - 1;
      if (slot == 0) base = next_index;
      prio[slot] = hi;
      n = slot + 1;
      next_index = next_index + 1'b1;
      packets++;
      if (n < span() && !fin) begin
        fill = n;
        return;
      end
      k = 0;
      for (int pass = 0; pass < 2; pass++) begin
        for (int i = 0; i < n; i++) begin
          if (prio[i] == (pass == 0)) begin
            k++;
            e.index = base + OUT_INDEX_W'(i);
            e.run_last = (k == n);
            due_q.push_back(e);
          end
        end
      end
      fill = 0;
      if (fin) next_index = '0;
    endfunction

    function void check_result(logic [OUT_INDEX_W-1:0] idx, logic last);
      sched_t want;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: index %0d last %0b with nothing outstanding", idx, last);
        return;
      end
      want = due_q.pop_front();
      if (want.index !== idx || want.run_last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected index %0d last %0b, got index %0d last %0b",
                   want.index, want.run_last, idx, last);
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'd0;    // [0] priority_high, [7:1] zero
  logic                   s_axis_tlast = 1'b0;    // sequence_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_INDEX_W-1:0] m_axis_tdata;           // [15:0] packet_index
  logic                   m_axis_tlast;           // run_last
  logic                   cfg_we = 1'b0;
  logic [WSIZE_W-1:0]     cfg_wdata = '0;

  window_scoreboard sb = new();
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned size_writes = 0;

  priority_window_scheduler_top #(
    .MAX_WINDOW (MAX_WINDOW),
    .INDEX_WIDTH(16)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Output side: check each transfer, then draw the stall before the next one.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
      sink_hold = sink_idle ? $urandom_range(0, 9) : 0;
    end
  end

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_packet(input logic hi, input logic fin);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, hi};
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_packet(hi, fin);
  endtask

  // Drain outstanding indices, then allow a scan to finish before touching config.
  task automatic quiesce();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window_size(input logic [WSIZE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_window_size(v);
    size_writes++;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[priority_window_scheduler_top] ERROR");
    $finish;
  end

  initial begin
    logic [WSIZE_W-1:0] sizes[8];
    int unsigned        count;
    sizes = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd2, 4'd5, 4'd6};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset size, full and partial windows, single-packet end.
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_packet(1'b1, 1'b0);
    send_packet(1'b0, 1'b0);
    send_packet(1'b1, 1'b0);
    send_packet(1'b0, 1'b0);
    send_packet(1'b0, 1'b1);
    send_packet(1'b1, 1'b1);
    // size zero behaves as one
    quiesce();
    write_window_size(4'd0);
    send_packet(1'b0, 1'b0);
    send_packet(1'b1, 1'b0);
    // oversize clamps to the full window
    quiesce();
    write_window_size(4'd15);
    foreach (sizes[i]) send_packet(logic'(i % 3 == 1), 1'b0);
    // shrink below the current fill: next packet flushes everything held
    quiesce();
    write_window_size(4'd8);
    repeat (5) send_packet(1'($urandom_range(0, 1)), 1'b0);
    quiesce();
    write_window_size(4'd2);
    send_packet(1'b1, 1'b0);
    send_packet(1'b0, 1'b1);

    // Random sequences over a spread of window sizes.
    foreach (sizes[p]) begin
      quiesce();
      write_window_size(p < 6 ? sizes[p] : WSIZE_W'($urandom_range(0, 15)));
      src_idle = (p != 2) && ($urandom_range(0, 3) != 0);
      sink_idle = (p != 2) && ($urandom_range(0, 3) != 0);
      count = $urandom_range(14, 18);
      repeat (count) send_packet(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    end

    quiesce();
    $display("Sent %0d packets across %0d window-size writes;",
             sb.packets, size_writes);
    $display("checked %0d scheduled indices with %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[priority_window_scheduler_top] OK");
    else
      $display("[priority_window_scheduler_top] ERROR");
    $finish;
  end

endmodule
